/* sv/sgcc_pkg.sv */
// Shared types and constants for the scan gap cluster centroid block.
// CORDIC arctangent table, rotation gain and register indexes.
// No dependencies.
package sgcc_pkg;

    localparam int unsigned GAIN_Q16 = 39797;
    localparam int unsigned CORDIC_XW = 36;
    localparam int unsigned CORDIC_ZW = 34;
    localparam int unsigned ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_SENSOR_X  = 3'd0,
        REG_SENSOR_Y  = 3'd1,
        REG_SENSOR_Z  = 3'd2,
        REG_START_ANG = 3'd3,
        REG_ANG_STEP  = 3'd4,
        REG_MIN_RANGE = 3'd5,
        REG_MAX_RANGE = 3'd6,
        REG_GAP_THR   = 3'd7
    } reg_idx_t;

    function automatic logic signed [CORDIC_ZW-1:0] atan_at(input logic [4:0] i);
        logic signed [CORDIC_ZW-1:0] r;
        begin
            case (i)
                5'd0:    r = 34'sd536870912;
                5'd1:    r = 34'sd316933406;
                5'd2:    r = 34'sd167458907;
                5'd3:    r = 34'sd85004756;
                5'd4:    r = 34'sd42667331;
                5'd5:    r = 34'sd21354465;
                5'd6:    r = 34'sd10679838;
                5'd7:    r = 34'sd5340245;
                5'd8:    r = 34'sd2670163;
                5'd9:    r = 34'sd1335087;
                5'd10:   r = 34'sd667544;
                5'd11:   r = 34'sd333772;
                5'd12:   r = 34'sd166886;
                5'd13:   r = 34'sd83443;
                5'd14:   r = 34'sd41722;
                5'd15:   r = 34'sd20861;
                5'd16:   r = 34'sd10430;
                5'd17:   r = 34'sd5215;
                5'd18:   r = 34'sd2608;
                5'd19:   r = 34'sd1304;
                5'd20:   r = 34'sd652;
                5'd21:   r = 34'sd326;
                5'd22:   r = 34'sd163;
                5'd23:   r = 34'sd81;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

/* sv/sgcc_cordic.sv */
// Iterative CORDIC rotation of a range reading by a binary angle.
// One rotation step per cycle through a shared shift and add unit.
// Depends on sgcc_pkg.
module sgcc_cordic #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [15:0]         range_in,
    input  logic [15:0]         angle_in,
    output logic                done,
    output logic signed [19:0]  rx,
    output logic signed [19:0]  ry
);
    import sgcc_pkg::*;

    localparam int unsigned IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    logic                          busy_reg;
    logic [IW-1:0]                 it_reg;
    logic signed [CORDIC_XW-1:0]   x_reg, y_reg;
    logic signed [CORDIC_ZW-1:0]   z_reg;
    logic signed [CORDIC_XW-1:0]   x0, dx, dy, xr, yr;
    logic signed [CORDIC_ZW-1:0]   at;
    logic [31:0]                   theta;
    logic                          flip;

    assign flip  = angle_in[15] ^ angle_in[14];
    assign theta = {angle_in[15] ^ flip, angle_in[14:0], 16'h0000};
    assign x0    = CORDIC_XW'(range_in) * CORDIC_XW'(GAIN_Q16);
    assign dx    = y_reg >>> it_reg;
    assign dy    = x_reg >>> it_reg;
    assign at    = atan_at(5'(it_reg));
    assign xr    = x_reg + CORDIC_XW'(33'sd32768);
    assign yr    = y_reg + CORDIC_XW'(33'sd32768);
    assign rx    = xr[35:16];
    assign ry    = yr[35:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            it_reg   <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
            end
            else if (busy_reg)
            begin
                if (it_reg == IW'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                else
                begin
                    it_reg <= it_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= flip ? -x0 : x0;
            y_reg <= '0;
            z_reg <= CORDIC_ZW'($signed(theta));
        end
        else if (busy_reg)
        begin
            if (!z_reg[CORDIC_ZW-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

endmodule

/* sv/sgcc_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Shared for both centroid coordinates. No package dependencies.
module sgcc_div #(
    parameter int unsigned DW = 43,
    parameter int unsigned NW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [NW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int unsigned CW = $clog2(DW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [NW-1:0] rem_reg, den_reg;
    logic [NW:0]   trial, diff;
    logic          fits;

    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign fits     = trial >= {1'b0, den_reg};
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[NW-1:0] : trial[NW-1:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

endmodule

/* sv/scan_gap_cluster_centroids.sv */
// Scan gap clustering: laser beams to cluster centroids.
// Sequence: a usable beam is rotated, checked for a gap if a cluster is open, then added to the cluster;
// a gap, an unusable beam or the scan end closes the cluster, whose centroid needs an X then a Y division.
// Throughput: one item at a time; the CORDIC and the divider iterate one step a cycle.
// A stalled centroid holds the sequencer before the next centroid is loaded.
// Reset: rst_n asynchronous; registers to defaults, no open cluster, angle at start.
module scan_gap_cluster_centroids #(
    parameter int unsigned MAX_BEAMS    = 1024,
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sgcc_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [15:0]                     range_mm,
    input  logic                            range_finite,
    input  logic                            scan_last,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [31:0]              centre_x,
    output logic signed [31:0]              centre_y,
    output logic signed [31:0]              centre_z,
    output logic                            end_of_scan,
    output logic                            last_in_run
);
    import sgcc_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_BEAMS) + 1;
    localparam int unsigned SUM_W = 33 + $clog2(MAX_BEAMS);

    typedef enum logic [11:0] {
        ST_IDLE = 12'b000000000001,
        ST_ROT  = 12'b000000000010,
        ST_PT   = 12'b000000000100,
        ST_DIFF = 12'b000000001000,
        ST_SQX  = 12'b000000010000,
        ST_SQY  = 12'b000000100000,
        ST_SQT  = 12'b000001000000,
        ST_DIVX = 12'b000010000000,
        ST_DIVY = 12'b000100000000,
        ST_EMIT = 12'b001000000000,
        ST_ADD  = 12'b010000000000,
        ST_END  = 12'b100000000000
    } state_t;

    state_t state_reg;

    logic signed [31:0] sx_reg, sy_reg, sz_reg;
    logic [15:0] start_reg, step_reg, minr_reg, maxr_reg, thr_reg;
    logic [15:0] beam_reg;

    logic        last_reg;
    logic [CNT_W-1:0] size_reg;
    logic signed [SUM_W-1:0] sumx_reg, sumy_reg;
    logic signed [31:0] prevx_reg, prevy_reg, px_reg, py_reg;
    logic [32:0] adx_reg, ady_reg, acc_reg;
    logic        eos_reg, lir_reg, to_add_reg, sel_y_reg;
    logic signed [31:0] qx_reg;
    logic signed [31:0] div_q_y_reg;

    logic wr;
    logic usable_in;
    logic cor_start, cor_done;
    logic signed [19:0] rx, ry;
    logic signed [33:0] spx, spy;
    logic signed [32:0] ddx, ddy;
    logic [15:0] sq_in;
    logic [31:0] sq;
    logic div_start, div_done;
    logic [SUM_W-1:0] div_in, div_q, mag;
    logic signed [SUM_W-1:0] sum_sel;
    logic [SUM_W-1:0] q_signed;
    logic out_free;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_comb
    begin
        unique case (reg_idx_t'(paddr[4:2]))
            REG_SENSOR_X:  prdata = sx_reg;
            REG_SENSOR_Y:  prdata = sy_reg;
            REG_SENSOR_Z:  prdata = sz_reg;
            REG_START_ANG: prdata = {16'h0, start_reg};
            REG_ANG_STEP:  prdata = {16'h0, step_reg};
            REG_MIN_RANGE: prdata = {16'h0, minr_reg};
            REG_MAX_RANGE: prdata = {16'h0, maxr_reg};
            REG_GAP_THR:   prdata = {16'h0, thr_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg    <= '0;
            sy_reg    <= '0;
            sz_reg    <= '0;
            start_reg <= '0;
            step_reg  <= '0;
            minr_reg  <= '0;
            maxr_reg  <= 16'hFFFF;
            thr_reg   <= 16'd500;
        end
        else if (wr)
        begin
            unique case (reg_idx_t'(paddr[4:2]))
                REG_SENSOR_X:  sx_reg    <= pwdata;
                REG_SENSOR_Y:  sy_reg    <= pwdata;
                REG_SENSOR_Z:  sz_reg    <= pwdata;
                REG_START_ANG: start_reg <= pwdata[15:0];
                REG_ANG_STEP:  step_reg  <= pwdata[15:0];
                REG_MIN_RANGE: minr_reg  <= pwdata[15:0];
                REG_MAX_RANGE: maxr_reg  <= pwdata[15:0];
                REG_GAP_THR:   thr_reg   <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign usable_in = range_finite && (range_mm >= minr_reg) && (range_mm < maxr_reg);

    assign cor_start = (state_reg == ST_IDLE) && in_valid && usable_in;

    sgcc_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cor_start),
        .range_in (range_mm),
        .angle_in (start_reg + beam_reg),
        .done     (cor_done),
        .rx       (rx),
        .ry       (ry)
    );

    assign spx = 34'(sx_reg) + 34'(rx);
    assign spy = 34'(sy_reg) + 34'(ry);
    assign ddx = 33'(px_reg) - 33'(prevx_reg);
    assign ddy = 33'(py_reg) - 33'(prevy_reg);

    always_comb
    begin
        case (state_reg)
            ST_SQX:  sq_in = adx_reg[15:0];
            ST_SQY:  sq_in = ady_reg[15:0];
            default: sq_in = thr_reg;
        endcase
    end
    assign sq = sq_in * sq_in;

    assign sum_sel  = sel_y_reg ? sumy_reg : sumx_reg;
    assign mag      = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    assign div_in   = mag + SUM_W'(size_reg >> 1);
    assign q_signed = sum_sel[SUM_W-1] ? -div_q : div_q;

    sgcc_div #(
        .DW(SUM_W),
        .NW(CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_in),
        .divisor  (size_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_free = !out_valid || !out_stall;

    logic div_go_reg;
    assign div_start = div_go_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            beam_reg   <= '0;
            size_reg   <= '0;
            sumx_reg   <= '0;
            sumy_reg   <= '0;
            out_valid  <= 1'b0;
            div_go_reg <= 1'b0;
            sel_y_reg  <= 1'b0;
            to_add_reg <= 1'b0;
            eos_reg    <= 1'b0;
            lir_reg    <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            div_go_reg <= 1'b0;
            if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg <= scan_last;
                        beam_reg <= scan_last ? 16'h0000 : beam_reg + step_reg;
                        if (usable_in)
                        begin
                            state_reg <= ST_ROT;
                        end
                        else if (size_reg != '0)
                        begin
                            eos_reg    <= 1'b0;
                            lir_reg    <= 1'b1;
                            to_add_reg <= 1'b0;
                            sel_y_reg  <= 1'b0;
                            div_go_reg <= 1'b1;
                            state_reg  <= ST_DIVX;
                        end
                        else
                        begin
                            state_reg <= ST_END;
                        end
                    end
                end
                ST_ROT:
                begin
                    if (cor_done)
                    begin
                        state_reg <= ST_PT;
                    end
                end
                ST_PT:
                begin
                    state_reg <= (size_reg != '0) ? ST_DIFF : ST_ADD;
                end
                ST_DIFF:
                begin
                    state_reg <= ST_SQX;
                end
                ST_SQX:
                begin
                    state_reg <= ST_SQY;
                end
                ST_SQY:
                begin
                    state_reg <= ST_SQT;
                end
                ST_SQT:
                begin
                    if ((adx_reg > 33'(thr_reg)) || (ady_reg > 33'(thr_reg))
                        || (acc_reg > 33'(sq)) || (size_reg >= CNT_W'(MAX_BEAMS)))
                    begin
                        eos_reg    <= 1'b0;
                        lir_reg    <= !last_reg;
                        to_add_reg <= 1'b1;
                        sel_y_reg  <= 1'b0;
                        div_go_reg <= 1'b1;
                        state_reg  <= ST_DIVX;
                    end
                    else
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_DIVX:
                begin
                    if (div_done)
                    begin
                        sel_y_reg  <= 1'b1;
                        div_go_reg <= 1'b1;
                        state_reg  <= ST_DIVY;
                    end
                end
                ST_DIVY:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid <= 1'b1;
                        size_reg  <= '0;
                        sumx_reg  <= '0;
                        sumy_reg  <= '0;
                        if (to_add_reg)
                        begin
                            state_reg <= ST_ADD;
                        end
                        else if (eos_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_END;
                        end
                    end
                end
                ST_ADD:
                begin
                    sumx_reg   <= sumx_reg + SUM_W'(px_reg);
                    sumy_reg   <= sumy_reg + SUM_W'(py_reg);
                    size_reg   <= size_reg + 1'b1;
                    to_add_reg <= 1'b0;
                    state_reg  <= ST_END;
                end
                ST_END:
                begin
                    if (last_reg && (size_reg != '0))
                    begin
                        eos_reg    <= 1'b1;
                        lir_reg    <= 1'b1;
                        to_add_reg <= 1'b0;
                        sel_y_reg  <= 1'b0;
                        div_go_reg <= 1'b1;
                        state_reg  <= ST_DIVX;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PT)
        begin
            px_reg <= (spx > 34'sd2147483647) ? 32'sh7FFFFFFF :
                      (spx < -34'sd2147483648) ? 32'sh80000000 : spx[31:0];
            py_reg <= (spy > 34'sd2147483647) ? 32'sh7FFFFFFF :
                      (spy < -34'sd2147483648) ? 32'sh80000000 : spy[31:0];
        end
        if (state_reg == ST_DIFF)
        begin
            adx_reg <= ddx[32] ? 33'(-ddx) : 33'(ddx);
            ady_reg <= ddy[32] ? 33'(-ddy) : 33'(ddy);
        end
        if (state_reg == ST_SQX)
        begin
            acc_reg <= 33'(sq);
        end
        if (state_reg == ST_SQY)
        begin
            acc_reg <= acc_reg + 33'(sq);
        end
        if (state_reg == ST_ADD)
        begin
            prevx_reg <= px_reg;
            prevy_reg <= py_reg;
        end
        if ((state_reg == ST_DIVX) && div_done)
        begin
            qx_reg <= q_signed[31:0];
        end
        if ((state_reg == ST_EMIT) && out_free)
        begin
            centre_x    <= qx_reg;
            centre_y    <= div_q_y_reg;
            centre_z    <= sz_reg;
            end_of_scan <= eos_reg;
            last_in_run <= lir_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DIVY) && div_done)
        begin
            div_q_y_reg <= q_signed[31:0];
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block not busy after accepting an item");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= CNT_W'(MAX_BEAMS))
        else $error("cluster size exceeds limit");

    a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_scan) |-> last_in_run)
        else $error("scan end centroid not last of its run");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && out_free) |=> (size_reg == '0) && out_valid)
        else $error("emitted cluster not cleared");

endmodule
